[design/emve_pkg.sv]
// Shared types and constants for the encoder velocity estimator.
package emve_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_PPR  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAD = 8'd1;
    localparam logic [15:0] PPR_RESET = 16'd2048;

    localparam int TS_W = 19;
    localparam logic [TS_W-1:0] TS_FALLBACK_US = 19'd1000;
    localparam logic [63:0] TS_MAX_US = 64'd500000;
    localparam logic [63:0] STOP_US   = 64'd100000;

    localparam int SINCE_CAP_BITS = 40;
    localparam logic [63:0] SINCE_CAP = (64'd1 << SINCE_CAP_BITS) - 64'd1;

    // 10^6 = 5^6 * 2^6; the Q16 shift and the 2^6 fold into one left shift
    localparam int MUL5_STEPS  = 6;
    localparam int MUL5_GROWTH = 14;
    localparam int RATE_LSH    = 22;
    localparam int RATE_QBITS  = 47;
    localparam int RATE_W      = 48;
    localparam logic [RATE_W-1:0] RATE_MAX = (48'd1 << RATE_QBITS) - 48'd1;

    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
    localparam int PROD_W     = RATE_QBITS + 32;
    localparam int VEL_FRAC   = 29;
    localparam int VEL_QBITS  = 32;
    localparam int VEL_HI_LSB = VEL_FRAC + VEL_QBITS;
    localparam int CPR_W      = 18;
    localparam logic [31:0] VEL_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VEL_NEG_MAX = 32'h8000_0000;

    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] MUL5_LAST = 6'(MUL5_STEPS - 1);
    localparam logic [CNT_W-1:0] RDIV_LAST = 6'(RATE_QBITS - 1);
    localparam logic [CNT_W-1:0] VDIV_LAST = 6'(VEL_QBITS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BRANCH,
        ST_MUL5,
        ST_RLOAD,
        ST_RDIV,
        ST_RSTORE,
        ST_VMULH,
        ST_VMULL,
        ST_VLOAD,
        ST_VDIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_sample;
        logic mul5_step;
        logic rate_load;
        logic div_step;
        logic rate_store;
        logic vmul_hi;
        logic vmul_lo;
        logic vel_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic rate_go;
        logic out_free;
    } status_t;

endpackage

[design/encoder_mixed_velocity_estimator_core.sv]
// Top level of the mixed time/frequency encoder velocity estimator.
// One sample is accepted at a time: s_ready is high only in the idle state, so a new word is taken
// only after the previous result is loaded into the output register; one bit-serial divider does
// 47 rate bits and then 32 velocity bits, one quotient bit per cycle.
// Reset (aresetn low, synchronous): sample history and held rate clear to zero,
// pulses_per_rev returns to 2048 and the x4 quadrature mode comes back on.
module encoder_mixed_velocity_estimator_core
    import emve_pkg::*;
#(
    parameter int TIME_WIDTH  = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [31:0]           s_now_us,
    input  logic signed [31:0]    s_pulse_count,
    input  logic [31:0]           s_last_pulse_us,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_velocity_q16,
    output logic                  m_stopped
);

    cmd_t    cmd;
    status_t status;

    emve_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    emve_datapath #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_now_us        (s_now_us),
        .s_pulse_count   (s_pulse_count),
        .s_last_pulse_us (s_last_pulse_us),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_velocity_q16  (m_velocity_q16),
        .m_stopped       (m_stopped)
    );

endmodule

[design/emve_ctrl.sv]
// Sequencer for the estimator: steps the datapath through rate and velocity.
module emve_ctrl
    import emve_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_BRANCH;
                end
            end
            ST_BRANCH: begin
                state_next = status.rate_go ? ST_MUL5 : ST_VMULH;
            end
            ST_MUL5: begin
                if (count_reg == MUL5_LAST) begin
                    state_next = ST_RLOAD;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_RLOAD: state_next = ST_RDIV;
            ST_RDIV: begin
                if (count_reg == RDIV_LAST) begin
                    state_next = ST_RSTORE;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_RSTORE: state_next = ST_VMULH;
            ST_VMULH:  state_next = ST_VMULL;
            ST_VMULL:  state_next = ST_VLOAD;
            ST_VLOAD:  state_next = ST_VDIV;
            ST_VDIV: begin
                if (count_reg == VDIV_LAST) begin
                    state_next = ST_FINISH;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready         = 1'b1;
                cmd.load_sample = s_valid;
            end
            ST_BRANCH: ;
            ST_MUL5:   cmd.mul5_step  = 1'b1;
            ST_RLOAD:  cmd.rate_load  = 1'b1;
            ST_RDIV:   cmd.div_step   = 1'b1;
            ST_RSTORE: cmd.rate_store = 1'b1;
            ST_VMULH:  cmd.vmul_hi    = 1'b1;
            ST_VMULL:  cmd.vmul_lo    = 1'b1;
            ST_VLOAD:  cmd.vel_load   = 1'b1;
            ST_VDIV:   cmd.div_step   = 1'b1;
            ST_FINISH: cmd.out_load   = status.out_free;
            default: ;
        endcase
    end

endmodule

[design/emve_datapath.sv]
// Datapath: sample state, shared shift-subtract divider, multiplier, output register.
module emve_datapath
    import emve_pkg::*;
#(
    parameter int TIME_WIDTH  = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [31:0]           s_now_us,
    input  logic signed [31:0]    s_pulse_count,
    input  logic [31:0]           s_last_pulse_us,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_velocity_q16,
    output logic                  m_stopped
);

    localparam int PSW     = (TIME_WIDTH > SINCE_CAP_BITS) ? SINCE_CAP_BITS : TIME_WIDTH;
    localparam int SPAN_W  = (PSW > TS_W) ? PSW : TS_W;
    localparam int DTW     = SPAN_W + 2;
    localparam int DVW     = ((DTW - 1) > CPR_W) ? (DTW - 1) : CPR_W;
    localparam int MW      = COUNT_WIDTH + MUL5_GROWTH;
    localparam int HI_SHIFT = RATE_QBITS - RATE_LSH;
    localparam int CMPW    = (MW > PROD_W) ? MW : PROD_W;
    localparam int NUMW    = RATE_QBITS;

    logic [15:0]             ppr_reg;
    logic                    quad_reg;
    logic [TIME_WIDTH-1:0]   prev_time_reg;
    logic [PSW-1:0]          psp_reg;
    logic [COUNT_WIDTH-1:0]  prev_cnt_reg;
    logic signed [RATE_W-1:0] held_reg;
    logic                    stopped_reg;
    logic                    rate_go_reg;
    logic                    dneg_reg;
    logic                    vneg_reg;
    logic                    sat_reg;
    logic [MW-1:0]           acc_reg;
    logic [DVW-1:0]          div_reg;
    logic [DVW-1:0]          rem_reg;
    logic [NUMW-1:0]         num_reg;
    logic [NUMW-1:0]         quo_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    m_valid_reg;
    logic [31:0]             m_vel_reg;
    logic                    m_stopped_reg;

    logic [TIME_WIDTH-1:0]   now_t, last_t, ts_raw, th;
    logic [COUNT_WIDTH-1:0]  cnt_t, d, dmag;
    logic                    dneg;
    logic                    ts_ok;
    logic [TS_W-1:0]         ts;
    logic                    stopped_now;
    logic [PSW-1:0]          psp_next;
    logic signed [DTW-1:0]   dt;
    logic                    dt_ok;
    logic                    rate_go_now;
    logic [17:0]             ppr_eff;
    logic [CPR_W-1:0]        cpr;
    logic [MW-1:0]           rate_hi;
    logic [DVW:0]            div_t;
    logic [DVW:0]            div_diff;
    logic                    div_ge;
    logic [RATE_W-1:0]       rate_mag;
    logic [RATE_QBITS-1:0]   held_mag;
    logic [15:0]             mul_b;
    logic [RATE_QBITS+15:0]  mul_p;
    logic [31:0]             q32;
    logic [31:0]             vmag;
    logic [31:0]             vel;

    assign now_t  = TIME_WIDTH'(s_now_us);
    assign last_t = TIME_WIDTH'(s_last_pulse_us);
    assign cnt_t  = COUNT_WIDTH'(s_pulse_count);
    assign ts_raw = now_t - prev_time_reg;
    assign th     = now_t - last_t;
    assign ts_ok  = (ts_raw != '0) && (64'(ts_raw) <= TS_MAX_US);
    assign ts     = ts_ok ? TS_W'(ts_raw) : TS_FALLBACK_US;
    assign stopped_now = 64'(th) > STOP_US;
    assign psp_next = (64'(th) > SINCE_CAP) ? PSW'(SINCE_CAP) : PSW'(th);

    assign d    = cnt_t - prev_cnt_reg;
    assign dneg = d[COUNT_WIDTH-1];
    assign dmag = dneg ? ('0 - d) : d;

    assign dt = $signed(DTW'(ts)) + $signed(DTW'(psp_reg)) - $signed(DTW'(th));
    assign dt_ok = !dt[DTW-1] && (|dt) && ({dt, 1'b0} > (DTW + 1)'(ts));
    assign rate_go_now = !stopped_now && (dmag != '0) && dt_ok;

    assign ppr_eff = (ppr_reg == '0) ? 18'd1 : 18'(ppr_reg);
    assign cpr     = quad_reg ? (ppr_eff << 2) : ppr_eff;

    assign rate_hi  = acc_reg >> HI_SHIFT;
    assign div_t    = {rem_reg, num_reg[NUMW-1]};
    assign div_diff = div_t - {1'b0, div_reg};
    assign div_ge   = div_t >= {1'b0, div_reg};

    assign rate_mag = sat_reg ? RATE_MAX : {1'b0, quo_reg};
    assign held_mag = held_reg[RATE_W-1] ? RATE_QBITS'(-held_reg) : RATE_QBITS'(held_reg);
    assign mul_b    = cmd.vmul_hi ? TWO_PI_Q29[31:16] : TWO_PI_Q29[15:0];
    assign mul_p    = held_mag * mul_b;

    assign q32 = quo_reg[31:0];
    always_comb begin
        if (vneg_reg) begin
            vmag = (sat_reg || (q32 > VEL_NEG_MAX)) ? VEL_NEG_MAX : q32;
            vel  = 32'd0 - vmag;
        end else begin
            vmag = (sat_reg || q32[31]) ? VEL_POS_MAX : q32;
            vel  = vmag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppr_reg  <= PPR_RESET;
            quad_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_PPR) begin
                ppr_reg <= cfg_wdata;
            end else if (cfg_index == REG_QUAD) begin
                quad_reg <= cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg <= '0;
            psp_reg       <= '0;
            prev_cnt_reg  <= '0;
            held_reg      <= '0;
        end else begin
            if (cmd.load_sample) begin
                prev_time_reg <= now_t;
                psp_reg       <= psp_next;
                prev_cnt_reg  <= cnt_t;
                if (stopped_now) begin
                    held_reg <= '0;
                end
            end else if (cmd.rate_store) begin
                held_reg <= dneg_reg ? -$signed(rate_mag) : $signed(rate_mag);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            stopped_reg <= stopped_now;
            rate_go_reg <= rate_go_now;
            dneg_reg    <= dneg;
            acc_reg     <= MW'(dmag);
            div_reg     <= DVW'(dt);
        end
        if (cmd.mul5_step) begin
            acc_reg <= acc_reg + (acc_reg << 2);
        end
        if (cmd.rate_load) begin
            sat_reg <= CMPW'(rate_hi) >= CMPW'(div_reg);
            rem_reg <= DVW'(rate_hi);
            num_reg <= {acc_reg[HI_SHIFT-1:0], {RATE_LSH{1'b0}}};
            quo_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= div_ge ? DVW'(div_diff) : DVW'(div_t);
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[NUMW-2:0], div_ge};
        end
        if (cmd.vmul_hi) begin
            prod_reg <= PROD_W'(mul_p);
        end
        if (cmd.vmul_lo) begin
            prod_reg <= (prod_reg << 16) + PROD_W'(mul_p);
        end
        if (cmd.vel_load) begin
            sat_reg  <= CMPW'(prod_reg[PROD_W-1:VEL_HI_LSB]) >= CMPW'(cpr);
            rem_reg  <= DVW'(prod_reg[PROD_W-1:VEL_HI_LSB]);
            num_reg  <= {prod_reg[VEL_HI_LSB-1:VEL_FRAC], {(NUMW - VEL_QBITS){1'b0}}};
            div_reg  <= DVW'(cpr);
            quo_reg  <= '0;
            vneg_reg <= held_reg[RATE_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_vel_reg     <= vel;
            m_stopped_reg <= stopped_reg;
        end
    end

    assign status.rate_go  = rate_go_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_velocity_q16 = $signed(m_vel_reg);
    assign m_stopped      = m_stopped_reg;

endmodule
